/* sv/pmq_pkg.sv */
// ----------------------------------------------------------------------------
// pmq_pkg: shared types and constants for the priority message queue
// Scan token carried along the cell chain, clear broadcast, status and
// register index codes, controller states.
// ----------------------------------------------------------------------------
package pmq_pkg;

  // Largest message body in bytes
  localparam int unsigned MSG_BYTES = 8;

  // Field widths fixed by the interface
  localparam int unsigned PRIO_W  = 5;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned STAT_W  = 2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SIZE_ERR    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_WOULD_BLOCK = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MSG_SIZE = 1'b0;
  localparam logic CFG_MAX_MSGS = 1'b1;

  // Request types
  localparam logic REQ_SEND = 1'b0;
  localparam logic REQ_RECV = 1'b1;

  // Token handed from cell to cell, one hop per cycle.
  // send: hit means a free cell has claimed the message.
  // receive: hit means prio/len/seq/data hold the best candidate so far.
  typedef struct packed {
    logic              valid;
    logic              recv;
    logic              hit;
    logic [PRIO_W-1:0] prio;
    logic [LEN_W-1:0]  len;
    logic [SEQ_W-1:0]  seq;
    logic [DATA_W-1:0] data;
  } pmq_tok_t;

  // Broadcast that frees the entry holding the given sequence number
  typedef struct packed {
    logic             en;
    logic [SEQ_W-1:0] seq;
  } pmq_clr_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } pmq_state_t;

endpackage

/* sv/pmq_cell.sv */
// ----------------------------------------------------------------------------
// pmq_cell: one queue entry of the cell chain
// Holds one message; claims a passing send token when free, replaces the
// candidate of a passing receive token when it ranks higher, and frees
// itself on a matching clear broadcast.
// ----------------------------------------------------------------------------
module pmq_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             below_cap,
  input  pmq_pkg::pmq_tok_t tok_i,
  input  pmq_pkg::pmq_clr_t clr_i,
  output pmq_pkg::pmq_tok_t tok_o
);

  logic                          used_r, used_nxt;
  logic [pmq_pkg::PRIO_W-1:0]    prio_r;
  logic [pmq_pkg::LEN_W-1:0]     len_r;
  logic [pmq_pkg::SEQ_W-1:0]     seq_r;
  logic [pmq_pkg::DATA_W-1:0]    data_r;
  pmq_pkg::pmq_tok_t             tok_r, tok_nxt;
  logic                          claim;
  logic                          better;
  logic [pmq_pkg::SEQ_W-1:0]     seq_diff;

  // Claim: first free cell below capacity takes the message
  assign claim = tok_i.valid && !tok_i.recv && !tok_i.hit && !used_r && below_cap;

  // Rank: higher priority wins, then older sequence (wrapped difference)
  assign seq_diff = tok_i.seq - seq_r;
  always_comb begin
    better = 1'b0;
    if (used_r) begin
      if (!tok_i.hit) begin
        better = 1'b1;
      end else if (prio_r > tok_i.prio) begin
        better = 1'b1;
      end else if (prio_r == tok_i.prio) begin
        better = (seq_diff != '0) && !seq_diff[pmq_pkg::SEQ_W-1];
      end
    end
  end

  // Next token and occupancy
  always_comb begin
    tok_nxt  = tok_i;
    used_nxt = used_r;
    if (claim) begin
      tok_nxt.hit = 1'b1;
      used_nxt    = 1'b1;
    end else if (tok_i.valid && tok_i.recv && better) begin
      tok_nxt.hit  = 1'b1;
      tok_nxt.prio = prio_r;
      tok_nxt.len  = len_r;
      tok_nxt.seq  = seq_r;
      tok_nxt.data = data_r;
    end
    if (clr_i.en && used_r && (seq_r == clr_i.seq)) begin
      used_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      tok_r  <= '0;
    end else begin
      used_r <= used_nxt;
      tok_r  <= tok_nxt;
    end
  end

  // Entry contents, written on claim
  always_ff @(posedge clk) begin
    if (claim) begin
      prio_r <= tok_i.prio;
      len_r  <= tok_i.len;
      seq_r  <= tok_i.seq;
      data_r <= tok_i.data;
    end
  end

  assign tok_o = tok_r;

endmodule

/* sv/priority_message_queue.sv */
// Result path: a request with a size error, or a send while the count is at
//   capacity, gives its result in the cycle after acceptance; any other request
//   passes through the head token register, every cell and then the result register.
// A scanned request holds busy high, so no new request is taken until its scan ends.
// Reset: all entries free, count and sequence zero, msg_size 8, max_msgs 16.
// The result strobe cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// priority_message_queue: non-blocking priority message queue
// Controller, configuration registers and a chain of QUEUE_DEPTH cells that
// a scan token walks to place a send or pick the best message to receive.
// ----------------------------------------------------------------------------
module priority_message_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_req_type,
  input  logic [7:0]                   in_length,
  input  logic [pmq_pkg::PRIO_W-1:0]   in_msg_prio,
  input  logic [pmq_pkg::DATA_W-1:0]   in_payload,
  // result channel
  output logic                         out_valid,
  output logic [pmq_pkg::STAT_W-1:0]   out_status,
  output logic [pmq_pkg::LEN_W-1:0]    out_len,
  output logic [pmq_pkg::PRIO_W-1:0]   out_prio,
  output logic [pmq_pkg::DATA_W-1:0]   out_payload,
  output logic [pmq_pkg::COUNT_W-1:0]  out_queue_count,
  // configuration port
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [4:0]                   cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CAP_W = (CNT_W > pmq_pkg::COUNT_W) ? CNT_W : pmq_pkg::COUNT_W;

  // Byte mask for the low n bytes
  function automatic logic [pmq_pkg::DATA_W-1:0] byte_mask(input logic [pmq_pkg::LEN_W-1:0] n);
    logic [pmq_pkg::DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < pmq_pkg::DATA_W / 8; b++) begin
      if (pmq_pkg::LEN_W'(b) < n) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

  pmq_pkg::pmq_state_t           state_r, state_nxt;
  logic [3:0]                    msg_size_r;
  logic [4:0]                    max_msgs_r;
  logic [CNT_W-1:0]              held_r, held_nxt;
  logic [pmq_pkg::SEQ_W-1:0]     next_seq_r, next_seq_nxt;
  pmq_pkg::pmq_tok_t             head_tok_r, head_tok_nxt;
  pmq_pkg::pmq_clr_t             clr;
  pmq_pkg::pmq_tok_t             tok [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH-1:0]        below_cap;

  logic                          out_valid_r, out_valid_nxt;
  logic [pmq_pkg::STAT_W-1:0]    out_status_r, out_status_nxt;
  logic [pmq_pkg::LEN_W-1:0]     out_len_r, out_len_nxt;
  logic [pmq_pkg::PRIO_W-1:0]    out_prio_r, out_prio_nxt;
  logic [pmq_pkg::DATA_W-1:0]    out_payload_r, out_payload_nxt;

  logic [3:0]                    eff_size;
  logic [CAP_W-1:0]              eff_cap;
  logic [CAP_W-1:0]              held_ext;
  logic [CAP_W-1:0]              held_nxt_ext;
  logic                          accept;
  logic                          size_err;
  logic                          full;
  pmq_pkg::pmq_tok_t             tok_end;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_size_r <= 4'd8;
      max_msgs_r <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmq_pkg::CFG_MSG_SIZE: msg_size_r <= cfg_wdata[3:0];
        pmq_pkg::CFG_MAX_MSGS: max_msgs_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturated settings
  always_comb begin
    eff_size = msg_size_r;
    if (eff_size == 4'd0) eff_size = 4'd1;
    if (eff_size > 4'(pmq_pkg::MSG_BYTES)) eff_size = 4'(pmq_pkg::MSG_BYTES);
    eff_cap = CAP_W'(max_msgs_r);
    if (eff_cap == '0) eff_cap = CAP_W'(1);
    if (eff_cap > CAP_W'(QUEUE_DEPTH)) eff_cap = CAP_W'(QUEUE_DEPTH);
  end

  // Request checks
  assign held_ext = CAP_W'(held_r);
  assign accept   = start && !busy;
  assign size_err = (in_req_type == pmq_pkg::REQ_SEND) ? (in_length > 8'(eff_size))
                                                       : (in_length < 8'(eff_size));
  assign full     = held_ext >= eff_cap;

  // Cell chain
  assign tok[0]  = head_tok_r;
  assign tok_end = tok[QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign below_cap[i] = CAP_W'(i) < eff_cap;
    pmq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .below_cap (below_cap[i]),
      .tok_i     (tok[i]),
      .clr_i     (clr),
      .tok_o     (tok[i+1])
    );
  end

  // Controller: next state, token launch and result
  always_comb begin
    state_nxt       = state_r;
    held_nxt        = held_r;
    next_seq_nxt    = next_seq_r;
    head_tok_nxt    = '0;
    clr             = '0;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = pmq_pkg::STAT_OK;
    out_len_nxt     = '0;
    out_prio_nxt    = '0;
    out_payload_nxt = '0;
    unique case (state_r)
      pmq_pkg::ST_IDLE: begin
        if (accept) begin
          if (size_err) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pmq_pkg::STAT_SIZE_ERR;
          end else if ((in_req_type == pmq_pkg::REQ_SEND) && full) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pmq_pkg::STAT_WOULD_BLOCK;
          end else begin
            head_tok_nxt.valid = 1'b1;
            head_tok_nxt.recv  = (in_req_type == pmq_pkg::REQ_RECV);
            if (in_req_type == pmq_pkg::REQ_SEND) begin
              head_tok_nxt.prio = in_msg_prio;
              head_tok_nxt.len  = in_length[pmq_pkg::LEN_W-1:0];
              head_tok_nxt.seq  = next_seq_r;
              head_tok_nxt.data = in_payload & byte_mask(in_length[pmq_pkg::LEN_W-1:0]);
            end
            state_nxt = pmq_pkg::ST_SCAN;
          end
        end
      end
      pmq_pkg::ST_SCAN: begin
        if (tok_end.valid) begin
          state_nxt     = pmq_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          if (!tok_end.hit) begin
            out_status_nxt = pmq_pkg::STAT_WOULD_BLOCK;
          end else if (tok_end.recv) begin
            out_len_nxt     = tok_end.len;
            out_prio_nxt    = tok_end.prio;
            out_payload_nxt = tok_end.data & byte_mask(tok_end.len);
            clr.en          = 1'b1;
            clr.seq         = tok_end.seq;
            if (held_r != '0) held_nxt = held_r - CNT_W'(1);
          end else begin
            held_nxt     = held_r + CNT_W'(1);
            next_seq_nxt = next_seq_r + 32'd1;
          end
        end
      end
      default: state_nxt = pmq_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pmq_pkg::ST_IDLE;
      held_r      <= '0;
      next_seq_r  <= '0;
      head_tok_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      next_seq_r  <= next_seq_nxt;
      head_tok_r  <= head_tok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_status_r  <= out_status_nxt;
      out_len_r     <= out_len_nxt;
      out_prio_r    <= out_prio_nxt;
      out_payload_r <= out_payload_nxt;
    end
  end

  // Outputs
  assign held_nxt_ext    = CAP_W'(held_r);
  assign busy            = (state_r != pmq_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_len         = out_len_r;
  assign out_prio        = out_prio_r;
  assign out_payload     = out_payload_r;
  assign out_queue_count = held_nxt_ext[pmq_pkg::COUNT_W-1:0];

endmodule
